// ===== hw/rtl/aed_pkg.sv =====
// Shared types, constants and helper functions for the archive entry descrambler.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package aed_pkg;

  localparam int TABLE_DEPTH      = 256;
  localparam int NAME_LEN_MAX     = 1024;
  localparam int SCRAMBLED_PREFIX = 4096;

  localparam int TIDX_W = $clog2(TABLE_DEPTH);
  localparam int NPOS_W = $clog2(NAME_LEN_MAX + 1);
  localparam int DPOS_W = $clog2(SCRAMBLED_PREFIX + NAME_LEN_MAX + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NAME_KEY_WORD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_KEY_SEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARCHIVE_KEY_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ARCHIVE_KEY_B = 2'd3;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_TABLE = 2'd0,
    KIND_START = 2'd1,
    KIND_NAME  = 2'd2,
    KIND_DATA  = 2'd3
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic tbl_write;
    logic start;
    logic key_stage_a;
    logic key_stage_b;
    logic emit_name;
    logic emit_data;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_ready;
    logic out_free;
  } dp_stat_t;

  // Sum of the four bytes of a word, mod 256.
  function automatic logic [7:0] byte_sum32(input logic [31:0] w);
    byte_sum32 = w[31:24] + w[23:16] + w[15:8] + w[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aed_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on aed_pkg for the item kind type.
`default_nettype none

interface aed_in_if;
  logic          valid;
  logic          ready;
  aed_pkg::kind_t kind;
  logic [7:0]    table_index;
  logic [7:0]    value;
  logic [31:0]   entry_index;
  logic [31:0]   original_size;

  modport source(output valid, kind, table_index, value, entry_index, original_size,
                 input ready);
  modport sink(input valid, kind, table_index, value, entry_index, original_size,
               output ready);
endinterface

interface aed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_name_byte;

  modport source(output valid, out_byte, is_name_byte, input ready);
  modport sink(input valid, out_byte, is_name_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/aed_datapath.sv =====
// Datapath: configuration registers, substitution table memory, per-entry
// counters, key arithmetic and the output register. Depends on aed_pkg.
`default_nettype none

module aed_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire aed_pkg::ctl_cmd_t               cmd,
  output aed_pkg::dp_stat_t                    stat,
  input  wire logic                            cfg_we,
  input  wire logic [aed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [aed_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [7:0]                      in_table_index,
  input  wire logic [7:0]                      in_value,
  input  wire logic [31:0]                     in_entry_index,
  input  wire logic [31:0]                     in_original_size,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [7:0]                           out_byte,
  output logic                                 out_is_name
);
  import aed_pkg::*;

  // Only the low bytes of the keys matter; the name key word is kept as its byte sum.
  logic [7:0] name_key_sum;
  logic [7:0] seed_lo;
  logic [7:0] key_a_lo;
  logic [7:0] key_b_lo;

  logic [7:0] subst_mem [TABLE_DEPTH];
  logic [7:0] tbl_rd;

  logic [7:0]        val_q;
  logic [7:0]        index_byte_sum;
  logic [NPOS_W-1:0] name_position;
  logic [7:0]        name_byte_sum;
  logic [DPOS_W-1:0] data_position;
  logic [7:0]        size_low_byte;
  logic [7:0]        entry_data_key;
  logic              data_key_ready;
  logic [7:0]        key_m1;
  logic [7:0]        key_m2;

  logic [7:0]        name_key;
  logic [7:0]        name_out;
  logic [DPOS_W-1:0] data_limit;
  logic              data_in_prefix;
  logic [7:0]        data_out;
  logic [7:0]        seed_diff;
  logic [15:0]       prod_m1;
  logic [15:0]       prod_m2;
  logic [7:0]        key_sum;
  logic [15:0]       prod_key;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      name_key_sum <= '0;
      seed_lo      <= '0;
      key_a_lo     <= '0;
      key_b_lo     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NAME_KEY_WORD: name_key_sum <= byte_sum32(cfg_data);
        REG_DATA_KEY_SEED: seed_lo      <= cfg_data[7:0];
        REG_ARCHIVE_KEY_A: key_a_lo     <= cfg_data[7:0];
        REG_ARCHIVE_KEY_B: key_b_lo     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Substitution table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.tbl_write) begin
      subst_mem[in_table_index[TIDX_W-1:0]] <= in_value;
    end
    if (cmd.load_item) begin
      tbl_rd <= subst_mem[in_value[TIDX_W-1:0]];
    end
  end

  // Name key: 0xFC times the position is minus four times it, mod 256.
  always_comb begin
    name_key = 8'd0 - {name_position[5:0], 2'b00} - name_key_sum - index_byte_sum;
    name_out = val_q + name_key;
  end

  // Data byte: table lookup less key and position inside the prefix.
  always_comb begin
    data_limit     = DPOS_W'(SCRAMBLED_PREFIX) + DPOS_W'(name_position);
    data_in_prefix = data_position < data_limit;
    data_out       = data_in_prefix ? (tbl_rd - entry_data_key - data_position[7:0]) : val_q;
  end

  // Data key arithmetic, one multiply level per cycle.
  always_comb begin
    seed_diff = seed_lo - name_byte_sum;
    prod_m1   = seed_diff * name_position[7:0];
    prod_m2   = key_a_lo * key_b_lo;
    key_sum   = key_m1 + key_m2;
    prod_key  = key_sum * size_low_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.key_stage_a) begin
      key_m1 <= prod_m1[7:0];
      key_m2 <= prod_m2[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      val_q <= in_value;
    end
  end

  // Per-entry state.
  always_ff @(posedge clk) begin
    if (rst) begin
      index_byte_sum <= '0;
      name_position  <= '0;
      name_byte_sum  <= '0;
      data_position  <= '0;
      size_low_byte  <= '0;
      entry_data_key <= '0;
      data_key_ready <= 1'b0;
    end else if (cmd.start) begin
      index_byte_sum <= byte_sum32(in_entry_index);
      size_low_byte  <= in_original_size[7:0];
      name_position  <= '0;
      name_byte_sum  <= '0;
      data_position  <= '0;
      entry_data_key <= '0;
      data_key_ready <= 1'b0;
    end else begin
      if (cmd.emit_name) begin
        name_byte_sum <= name_byte_sum + name_out;
        if (name_position < NPOS_W'(NAME_LEN_MAX)) begin
          name_position <= name_position + 1'b1;
        end
      end
      if (cmd.key_stage_b) begin
        entry_data_key <= prod_key[7:0];
        data_key_ready <= 1'b1;
      end
      if (cmd.emit_data && data_in_prefix) begin
        data_position <= data_position + 1'b1;
      end
    end
  end

  // Output register; it frees when the result item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_name || cmd.emit_data) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_name) begin
      out_byte    <= name_out;
      out_is_name <= 1'b1;
    end else if (cmd.emit_data) begin
      out_byte    <= data_out;
      out_is_name <= 1'b0;
    end
  end

  assign stat.key_ready = data_key_ready;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/aed_ctrl.sv =====
// Controller: sequences one item at a time through key forming and result emission.
// Depends on aed_pkg for the command and status structs and the item kinds.
`default_nettype none

module aed_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire aed_pkg::kind_t    in_kind,
  output logic                   in_ready,
  input  wire aed_pkg::dp_stat_t stat,
  output aed_pkg::ctl_cmd_t      cmd
);
  import aed_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_A,
    ST_KEY_B,
    ST_EMIT_NAME,
    ST_EMIT_DATA
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Commands follow the state and, while idle, the accepted item.
  always_comb begin
    cmd             = '0;
    cmd.load_item   = accept;
    cmd.tbl_write   = accept && (in_kind == KIND_TABLE);
    cmd.start       = accept && (in_kind == KIND_START);
    cmd.key_stage_a = (state == ST_KEY_A);
    cmd.key_stage_b = (state == ST_KEY_B);
    cmd.emit_name   = (state == ST_EMIT_NAME) && stat.out_free;
    cmd.emit_data   = (state == ST_EMIT_DATA) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_kind)
              KIND_NAME: state <= ST_EMIT_NAME;
              KIND_DATA: state <= stat.key_ready ? ST_EMIT_DATA : ST_KEY_A;
              default:   state <= ST_IDLE;
            endcase
          end
        end
        ST_KEY_A: state <= ST_KEY_B;
        ST_KEY_B: state <= ST_EMIT_DATA;
        ST_EMIT_NAME, ST_EMIT_DATA: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/archive_entry_descrambler.sv =====
// Archive entry descrambler, top level. Table load and start items are taken in the idle
// state and leave the block idle. A name byte, or a data byte whose key is formed, goes to
// an emit state that registers its result in the output register; the first data byte of an
// entry first passes the key states KEY_A and KEY_B, the two registered multiply levels of the key.
// An emit state waits while the output register holds an untaken result; one item at a time.
// Reset clears the configuration, counters and control; the table stays undefined.
`default_nettype none

module archive_entry_descrambler (
  input  wire logic                            clk,
  input  wire logic                            rst,
  aed_in_if.sink                               in_ch,
  aed_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [aed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [aed_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import aed_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Item sequencing.
  aed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table, counters, keys and result register.
  aed_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_table_index   (in_ch.table_index),
    .in_value         (in_ch.value),
    .in_entry_index   (in_ch.entry_index),
    .in_original_size (in_ch.original_size),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_byte         (out_ch.out_byte),
    .out_is_name      (out_ch.is_name_byte)
  );

endmodule

`default_nettype wire

// ===== verif/archive_entry_descrambler_check.sv =====
`timescale 1ns / 1ps
// Result checker for the archive entry descrambler: watches both item channels and
// the register write port, predicts every result and compares it field by field.
// Depends on aed_pkg and on the channel interfaces in aed_if.sv.

module archive_entry_descrambler_check
  import aed_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  aed_in_if           in_mon,
  aed_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       name_flag;
  } byte_result_t;

  // Own copy of the registers and of the per-entry state.
  logic [31:0]       cfg_name_word;
  logic [31:0]       cfg_seed;
  logic [31:0]       cfg_mult_a;
  logic [31:0]       cfg_mult_b;
  logic [7:0]        sub_tbl [TABLE_DEPTH];
  logic [7:0]        idx_fold;
  logic [NPOS_W-1:0] name_cnt;
  logic [7:0]        name_fold;
  logic [DPOS_W-1:0] data_cnt;
  logic [7:0]        size_lsb;
  logic [7:0]        entry_key;
  logic              key_valid;

  byte_result_t expected_bytes [$];
  int           errors;

  assign fail_count = errors;

  initial errors = 0;

  // Four bytes of a word added together, mod 256.
  function automatic logic [7:0] fold_bytes(input logic [31:0] w);
    logic [7:0] acc;
    acc = w[7:0];
    acc = acc + w[15:8];
    acc = acc + w[23:16];
    acc = acc + w[31:24];
    return acc;
  endfunction

  // Prediction and comparison, one step per clock edge.
  always @(posedge clk) begin
    byte_result_t want;
    logic [7:0]   nkey;
    logic [7:0]   plain;
    if (rst) begin
      cfg_name_word = '0;
      cfg_seed      = '0;
      cfg_mult_a    = '0;
      cfg_mult_b    = '0;
      idx_fold      = '0;
      name_cnt      = '0;
      name_fold     = '0;
      data_cnt      = '0;
      size_lsb      = '0;
      entry_key     = '0;
      key_valid     = 1'b0;
      expected_bytes.delete();
    end else begin
      // Register writes take effect at the edge that carries them.
      if (cfg_we) begin
        case (cfg_index)
          REG_NAME_KEY_WORD: cfg_name_word = cfg_data;
          REG_DATA_KEY_SEED: cfg_seed      = cfg_data;
          REG_ARCHIVE_KEY_A: cfg_mult_a    = cfg_data;
          REG_ARCHIVE_KEY_B: cfg_mult_b    = cfg_data;
          default: ;
        endcase
      end

      // A result item is matched against the oldest expectation.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual byte %02h name %0b",
                     $time, out_mon.out_byte, out_mon.is_name_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (out_mon.out_byte !== want.byte_val) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: out_byte expected %02h, actual %02h",
                       $time, want.byte_val, out_mon.out_byte);
          end
          if (out_mon.is_name_byte !== want.name_flag) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: is_name_byte expected %0b, actual %0b",
                       $time, want.name_flag, out_mon.is_name_byte);
          end
        end
      end

      // An accepted input item updates the state and may add an expectation.
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.kind)
          KIND_TABLE: sub_tbl[in_mon.table_index] = in_mon.value;
          KIND_START: begin
            idx_fold  = fold_bytes(in_mon.entry_index);
            size_lsb  = in_mon.original_size[7:0];
            name_cnt  = '0;
            name_fold = '0;
            data_cnt  = '0;
            entry_key = '0;
            key_valid = 1'b0;
          end
          KIND_NAME: begin
            nkey      = 8'hFC * name_cnt[7:0] - fold_bytes(cfg_name_word) - idx_fold;
            plain     = in_mon.value + nkey;
            name_fold = name_fold + plain;
            // The name counter saturates, the byte sum keeps running.
            if (int'(name_cnt) < NAME_LEN_MAX)
              name_cnt = name_cnt + 1'b1;
            want.byte_val  = plain;
            want.name_flag = 1'b1;
            expected_bytes = {expected_bytes, want};
          end
          KIND_DATA: begin
            // The data key is formed once per entry, at its first data byte.
            if (!key_valid) begin
              nkey      = cfg_seed[7:0] - name_fold;
              nkey      = nkey * name_cnt[7:0];
              nkey      = nkey + cfg_mult_a[7:0] * cfg_mult_b[7:0];
              nkey      = nkey * size_lsb;
              entry_key = nkey;
              key_valid = 1'b1;
            end
            // Only the scrambled prefix goes through the table; the rest passes.
            plain = in_mon.value;
            if (int'(data_cnt) < SCRAMBLED_PREFIX + int'(name_cnt)) begin
              plain    = sub_tbl[in_mon.value] - entry_key - data_cnt[7:0];
              data_cnt = data_cnt + 1'b1;
            end
            want.byte_val  = plain;
            want.name_flag = 1'b0;
            expected_bytes = {expected_bytes, want};
          end
          default: ;
        endcase
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

// ===== verif/archive_entry_descrambler_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the archive entry descrambler: clock, reset, register writes,
// directed and random item streams, result-side stalls and the final verdict.
// Depends on aed_pkg, aed_if.sv, the block and archive_entry_descrambler_check.

module archive_entry_descrambler_tb;
  import aed_pkg::*;

  localparam int RESET_CYCLES     = 8;
  localparam int SETTLE_CYCLES    = 12;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS      = 210;
  localparam int CALM_ITEMS       = 100;
  // About 1900 items, plus stalls and the long hold-off, stay well under a fifth of this.
  localparam int CYCLE_LIMIT      = 900000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          items_sent = 0;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          slot_written [TABLE_DEPTH];
  logic [7:0]  written_slots [$];

  aed_in_if  in_ch ();
  aed_out_if out_ch ();

  archive_entry_descrambler dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  archive_entry_descrambler_check u_check (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("archive_entry_descrambler: mismatch");
      $finish;
    end
  end

  // Result side: random stalls, none in a calm stretch, and one long hold-off.
  initial begin : result_sink
    bit hold_taken;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  function automatic logic [7:0] rand8();
    return 8'($urandom);
  endfunction

  // Data bytes only index table slots that have been loaded.
  function automatic logic [7:0] pick_value();
    return written_slots[$urandom_range(written_slots.size() - 1)];
  endfunction

  // Offers one item after a random gap and waits until it is accepted.
  task automatic send_item(input kind_t k, input logic [7:0] slot, input logic [7:0] val,
                           input logic [31:0] eidx, input logic [31:0] osize);
    while (!calm && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= k;
    in_ch.table_index   <= slot;
    in_ch.value         <= val;
    in_ch.entry_index   <= eidx;
    in_ch.original_size <= osize;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_slot(input logic [7:0] slot, input logic [7:0] val);
    send_item(KIND_TABLE, slot, val, $urandom, $urandom);
    if (!slot_written[slot]) begin
      slot_written[slot] = 1'b1;
      written_slots = {written_slots, slot};
    end
  endtask

  // Stops offering items until every expected result has come and the block is quiet.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keys(input logic [31:0] name_word, input logic [31:0] seed,
                            input logic [31:0] mult_a, input logic [31:0] mult_b);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NAME_KEY_WORD;
    cfg_data  <= name_word;
    @(posedge clk);
    cfg_index <= REG_DATA_KEY_SEED;
    cfg_data  <= seed;
    @(posedge clk);
    cfg_index <= REG_ARCHIVE_KEY_A;
    cfg_data  <= mult_a;
    @(posedge clk);
    cfg_index <= REG_ARCHIVE_KEY_B;
    cfg_data  <= mult_b;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed entries with random content, some table loads and noise.
  task automatic run_random(input int n);
    int    stop;
    int    r;
    int    nlen;
    int    dlen;
    kind_t k;
    stop = items_sent + n;
    while (items_sent < stop) begin
      r = $urandom_range(99);
      if (r < 15) begin
        load_slot(rand8(), rand8());
      end else if (r < 88) begin
        send_item(KIND_START, rand8(), rand8(), $urandom, $urandom);
        nlen = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(8);
        dlen = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(10);
        repeat (nlen) send_item(KIND_NAME, rand8(), rand8(), $urandom, $urandom);
        repeat (dlen) send_item(KIND_DATA, rand8(), pick_value(), $urandom, $urandom);
        // Now and then a name byte arrives after data has begun.
        if ($urandom_range(9) == 0) begin
          send_item(KIND_NAME, rand8(), rand8(), $urandom, $urandom);
          repeat ($urandom_range(3)) send_item(KIND_DATA, rand8(), pick_value(), $urandom,
                                               $urandom);
        end
      end else begin
        k = kind_t'(2'($urandom_range(3)));
        if (k == KIND_TABLE)
          load_slot(rand8(), rand8());
        else if (k == KIND_DATA)
          send_item(k, rand8(), pick_value(), $urandom, $urandom);
        else
          send_item(k, rand8(), rand8(), $urandom, $urandom);
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_NAME_KEY_WORD;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_TABLE;
    in_ch.table_index   <= '0;
    in_ch.value         <= '0;
    in_ch.entry_index   <= '0;
    in_ch.original_size <= '0;
    foreach (slot_written[i]) slot_written[i] = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset register values.
    load_slot(8'h00, 8'hFF);
    load_slot(8'hFF, 8'h00);
    load_slot(8'h5A, 8'hA5);
    load_slot(8'hA5, 8'h5A);
    load_slot(8'h01, 8'h80);
    // Data before any start item uses the counters as they come out of reset.
    send_item(KIND_DATA, 8'h00, 8'h00, '0, '0);
    send_item(KIND_DATA, 8'h00, 8'hFF, '0, '0);
    send_item(KIND_START, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_NAME, 8'h00, 8'h00, '0, '0);
    send_item(KIND_NAME, 8'h00, 8'hFF, '0, '0);
    send_item(KIND_NAME, 8'h00, 8'h5A, '0, '0);
    send_item(KIND_DATA, 8'h00, 8'hA5, '0, '0);
    send_item(KIND_DATA, 8'h00, 8'h5A, '0, '0);
    drain_results();

    // Directed part with every register at its maximum.
    write_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_START, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_00FF);
    send_item(KIND_NAME, 8'h00, 8'hFF, '0, '0);
    send_item(KIND_NAME, 8'h00, 8'h00, '0, '0);
    send_item(KIND_DATA, 8'h00, 8'h00, '0, '0);
    // A name byte after data: the data key stays, the prefix grows.
    send_item(KIND_NAME, 8'h00, 8'h01, '0, '0);
    send_item(KIND_DATA, 8'h00, 8'h01, '0, '0);
    send_item(KIND_DATA, 8'h00, 8'hFF, '0, '0);
    // An entry with an empty name.
    send_item(KIND_START, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_item(KIND_DATA, 8'h00, 8'h5A, '0, '0);
    load_slot(8'h00, 8'h00);
    send_item(KIND_DATA, 8'h00, 8'h00, '0, '0);
    drain_results();

    // A name longer than NAME_LEN_MAX, where the name counter saturates, then a few data bytes.
    write_keys($urandom, $urandom, $urandom, $urandom);
    send_item(KIND_START, rand8(), rand8(), $urandom, $urandom);
    repeat (NAME_LEN_MAX + 6) send_item(KIND_NAME, rand8(), rand8(), $urandom, $urandom);
    repeat (4) send_item(KIND_DATA, rand8(), pick_value(), $urandom, $urandom);
    drain_results();

    // Random phases; the first opens with a stretch free of any idling.
    write_keys('0, '0, '0, '0);
    calm <= 1'b1;
    run_random(CALM_ITEMS);
    calm <= 1'b0;
    run_random(PHASE_ITEMS - CALM_ITEMS);
    drain_results();

    // The result side holds off for a long stretch while items keep coming.
    write_keys($urandom, $urandom, $urandom, $urandom);
    long_hold_req <= 1'b1;
    run_random(PHASE_ITEMS);
    drain_results();

    write_keys(32'h0102_0304, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    run_random(PHASE_ITEMS);
    drain_results();

    write_keys($urandom, $urandom, $urandom, $urandom);
    run_random(PHASE_ITEMS);
    drain_results();

    if (fail_count == 0)
      $display("archive_entry_descrambler: match");
    else
      $display("archive_entry_descrambler: mismatch");
    $finish;
  end

endmodule
